[design/avcc_pkg.sv]
// Shared constants and helpers for the length-prefix to start-code converter.
package avcc_pkg;

  // Annex B start code, most significant byte first
  localparam logic [31:0] START_CODE = 32'h0000_0001;

  // NAL unit header fields
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_IDR       = 5'h05;
  localparam logic [4:0] NAL_SEI       = 5'h06;
  localparam logic [4:0] NAL_SPS       = 5'h07;
  localparam logic [4:0] NAL_PPS       = 5'h08;

  // Start code byte that sits 'back' bytes before the end of the prefix
  function automatic logic [7:0] start_code_byte(input logic [1:0] back);
    start_code_byte = START_CODE[8*back +: 8];
  endfunction

endpackage

[design/avcc_if.sv]
// Valid/ready channel interfaces for the converter's input and output items.
interface avcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       sample_end;

  modport source (output valid, output in_byte, output sample_end, input ready);
  modport sink   (input valid, input in_byte, input sample_end, output ready);
endinterface

interface avcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  logic       is_key;
  logic       need_param_sets;
  logic       truncated;

  modport source (output valid, output out_byte, output out_end, output is_key,
                  output need_param_sets, output truncated, input ready);
  modport sink   (input valid, input out_byte, input out_end, input is_key,
                  input need_param_sets, input truncated, output ready);
endinterface

[design/avcc_to_annexb_converter_unit.sv]
// Top level: H.264 length-prefixed sample to Annex B byte stream converter.
// Takes one sample byte per item and returns one converted byte per item
// through a single output register. A new item is taken
// every clock while the output register is empty or being emptied in the same
// cycle, so the sustained rate is one byte per clock; the per-byte work is a
// prefix-byte counter, a length shift register and a body-byte down counter.
// Each PREFIX_BYTES-long big-endian NAL length is replaced in place by the tail
// of the start code 00 00 00 01. On the byte flagged sample_end the result
// carries is_key, need_param_sets and truncated, and the parser returns to its
// reset state for the next sample; on other bytes those flags are zero.
module avcc_to_annexb_converter_unit #(
  parameter int PREFIX_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  avcc_in_if.sink    in_i,
  avcc_out_if.source out_o
);
  import avcc_pkg::*;

  localparam int LenW = 8 * PREFIX_BYTES;
  localparam int PosW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(PREFIX_BYTES - 1);

  // Parser state
  logic [PosW-1:0] prefix_pos_q, prefix_pos_d;
  logic [LenW-1:0] length_acc_q, length_acc_d;
  logic [LenW-1:0] bytes_left_q, bytes_left_d;
  logic            type_pending_q, type_pending_d;
  logic            seen_sps_q, seen_sps_d;
  logic            key_seen_q, key_seen_d;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_end_q;
  logic       is_key_q, is_key_d;
  logic       need_ps_q, need_ps_d;
  logic       trunc_q, trunc_d;

  logic            in_accept;
  logic            in_body;
  logic [LenW-1:0] acc_shift;
  logic [1:0]      sc_back;
  logic [4:0]      nal_type;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  assign in_body   = (bytes_left_q != '0);
  assign acc_shift = LenW'({length_acc_q, in_i.in_byte});
  assign sc_back   = 2'(PREFIX_BYTES - 1 - int'(prefix_pos_q));
  assign nal_type  = in_i.in_byte[4:0] & NAL_TYPE_MASK;

  // Per-byte parse: body byte pass-through or prefix byte replacement
  always_comb begin
    prefix_pos_d   = prefix_pos_q;
    length_acc_d   = length_acc_q;
    bytes_left_d   = bytes_left_q;
    type_pending_d = type_pending_q;
    seen_sps_d     = seen_sps_q;
    key_seen_d     = key_seen_q;
    out_byte_d     = in_i.in_byte;
    is_key_d       = 1'b0;
    need_ps_d      = 1'b0;
    trunc_d        = 1'b0;

    if (in_body) begin
      // first body byte is the NAL header
      if (type_pending_q) begin
        type_pending_d = 1'b0;
        if (nal_type == NAL_SPS) begin
          seen_sps_d = 1'b1;
          key_seen_d = 1'b1;
        end else if (!seen_sps_q && (nal_type inside {NAL_PPS, NAL_SEI, NAL_IDR})) begin
          key_seen_d = 1'b1;
        end
      end
      bytes_left_d = bytes_left_q - LenW'(1);
    end else begin
      out_byte_d = start_code_byte(sc_back);
      if (prefix_pos_q == PosLast) begin
        // prefix complete: load body count, empty NALs get no header check
        bytes_left_d   = acc_shift;
        type_pending_d = (acc_shift != '0);
        prefix_pos_d   = '0;
        length_acc_d   = '0;
      end else begin
        length_acc_d = acc_shift;
        prefix_pos_d = prefix_pos_q + PosW'(1);
      end
    end

    // sample summary, then clear for the next sample
    if (in_i.sample_end) begin
      is_key_d       = key_seen_d;
      need_ps_d      = key_seen_d && !seen_sps_d;
      trunc_d        = (prefix_pos_d != '0) || (bytes_left_d != '0);
      prefix_pos_d   = '0;
      length_acc_d   = '0;
      bytes_left_d   = '0;
      type_pending_d = 1'b0;
      seen_sps_d     = 1'b0;
      key_seen_d     = 1'b0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_pos_q   <= '0;
      length_acc_q   <= '0;
      bytes_left_q   <= '0;
      type_pending_q <= 1'b0;
      seen_sps_q     <= 1'b0;
      key_seen_q     <= 1'b0;
    end else if (in_accept) begin
      prefix_pos_q   <= prefix_pos_d;
      length_acc_q   <= length_acc_d;
      bytes_left_q   <= bytes_left_d;
      type_pending_q <= type_pending_d;
      seen_sps_q     <= seen_sps_d;
      key_seen_q     <= key_seen_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_byte_q <= out_byte_d;
      out_end_q  <= in_i.sample_end;
      is_key_q   <= is_key_d;
      need_ps_q  <= need_ps_d;
      trunc_q    <= trunc_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_byte        = out_byte_q;
  assign out_o.out_end         = out_end_q;
  assign out_o.is_key          = is_key_q;
  assign out_o.need_param_sets = need_ps_q;
  assign out_o.truncated       = trunc_q;

  // Checks
  a_end_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.sample_end |=>
      prefix_pos_q == '0 && bytes_left_q == '0 && !key_seen_q && !seen_sps_q)
    else $error("parser state not cleared after sample end");

  a_flags_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_end_q |-> !is_key_q && !need_ps_q && !trunc_q)
    else $error("summary flags set on a non-final byte");

  a_need_implies_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && need_ps_q |-> is_key_q)
    else $error("need_param_sets without keyframe");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_accept)
    else $error("pending output item overwritten");

endmodule

[sim/tb_avcc_to_annexb_converter_unit.sv]
// Testbench for the length-prefix to start-code converter: directed and random samples.
`timescale 1ns / 100ps

module tb_avcc_to_annexb_converter_unit;
  import avcc_pkg::*;

  localparam int PREFIX_BYTES = 4;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int MAX_PRINTS   = 30;

  // One converted byte with its end-of-sample flags
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic       is_key;
    logic       need_param_sets;
    logic       truncated;
  } annexb_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  avcc_in_if  in_if ();
  avcc_out_if out_if ();

  avcc_to_annexb_converter_unit #(.PREFIX_BYTES(PREFIX_BYTES)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted parser state
  logic [2:0]   len_pos;
  logic [31:0]  len_shift;
  logic [31:0]  body_left;
  logic         hdr_pending;
  logic         sps_in_sample;
  logic         key_in_sample;

  annexb_item_t annexb_expected_q[$];
  logic [7:0]   sample_q[$];

  int unsigned errors       = 0;
  int unsigned sent_items   = 0;
  int unsigned burst_left   = 0;
  bit          sender_steady = 1'b0;
  bit          hold_req     = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned idle_cycles  = 0;
  int unsigned n_results    = 0;
  int unsigned n_samples    = 0;
  int unsigned n_key        = 0;
  int unsigned n_param      = 0;
  int unsigned n_trunc      = 0;

  task automatic report_error(input string msg);
    if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic clear_parser();
    len_pos       = '0;
    len_shift     = '0;
    body_left     = '0;
    hdr_pending   = 1'b0;
    sps_in_sample = 1'b0;
    key_in_sample = 1'b0;
  endtask

  // Start code byte that replaces prefix byte 'pos'
  function automatic logic [7:0] code_byte(input logic [2:0] pos);
    int unsigned back;
    if (pos >= PREFIX_BYTES) return 8'h00;
    back = PREFIX_BYTES - 1 - pos;
    if (back > 3) return 8'h00;
    return 8'((START_CODE >> (8 * back)) & 32'hFF);
  endfunction

  // Advance the predicted parser by one accepted byte and queue its result
  task automatic convert_byte(input logic [7:0] b, input logic last);
    annexb_item_t x;
    logic [4:0]   nal_type;
    x = '0;
    if (body_left != 0) begin
      if (hdr_pending) begin
        nal_type = b[4:0] & NAL_TYPE_MASK;
        if (nal_type == NAL_SPS) begin
          sps_in_sample = 1'b1;
          key_in_sample = 1'b1;
        end else if (!sps_in_sample &&
                     (nal_type == NAL_PPS || nal_type == NAL_SEI || nal_type == NAL_IDR)) begin
          key_in_sample = 1'b1;
        end
        hdr_pending = 1'b0;
      end
      body_left = body_left - 1;
      x.out_byte = b;
    end else begin
      x.out_byte = code_byte(len_pos);
      len_shift  = {len_shift[23:0], b};
      len_pos    = len_pos + 3'd1;
      if (len_pos >= PREFIX_BYTES) begin
        body_left   = len_shift;
        hdr_pending = (len_shift != 0);
        len_pos     = '0;
        len_shift   = '0;
      end
    end
    x.out_end = last;
    if (last) begin
      x.is_key          = key_in_sample;
      x.need_param_sets = key_in_sample && !sps_in_sample;
      x.truncated       = (len_pos != 0) || (body_left != 0);
      clear_parser();
    end
    annexb_expected_q.push_back(x);
  endtask

  // Offer one item, in bursts with random gaps, and predict it once taken
  task automatic send_item(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0 && !sender_steady) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.sample_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sent_items++;
    convert_byte(b, last);
  endtask

  // Sample building: big-endian length prefix, then NAL header and body
  task automatic push_prefix(input logic [31:0] len);
    for (int i = PREFIX_BYTES - 1; i >= 0; i--) sample_q.push_back(len[8*i +: 8]);
  endtask

  task automatic push_nal(input logic [7:0] hdr, input int unsigned body_len);
    push_prefix(32'(body_len + 1));
    sample_q.push_back(hdr);
    repeat (body_len) sample_q.push_back(8'($urandom));
  endtask

  task automatic send_sample();
    for (int i = 0; i < sample_q.size(); i++) send_item(sample_q[i], i == sample_q.size() - 1);
    sample_q.delete();
  endtask

  function automatic logic [7:0] random_header();
    logic [4:0] t;
    case ($urandom_range(0, 9))
      0, 1:    t = NAL_SPS;
      2:       t = NAL_PPS;
      3:       t = NAL_SEI;
      4, 5:    t = NAL_IDR;
      6:       t = 5'd1;
      default: t = 5'($urandom);
    endcase
    return {3'($urandom), t};
  endfunction

  // Well-formed sample of 1 to 4 NALs, some of them empty
  task automatic build_sample();
    int unsigned body_len;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 9) == 0) begin
        push_prefix(32'd0);
      end else begin
        body_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 10);
        push_nal(random_header(), body_len);
      end
    end
  endtask

  // Receiver: long hold on request, else a stall pattern that changes mode
  initial begin : receiver
    rx_mode_e    rx_mode;
    int unsigned mode_left;
    int unsigned phase;
    rx_mode   = RX_OPEN;
    mode_left = 0;
    phase     = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        phase++;
        case (rx_mode)
          RX_OPEN:     out_if.ready <= 1'b1;
          RX_LIGHT:    out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY:    out_if.ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_if.ready <= (phase % 3 != 0);
          default:     out_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    annexb_item_t got;
    annexb_item_t exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.out_byte, out_if.out_end, out_if.is_key,
              out_if.need_param_sets, out_if.truncated};
      n_results++;
      if (annexb_expected_q.size() == 0) begin
        report_error($sformatf("unexpected result byte=%h end=%b", got.out_byte, got.out_end));
      end else begin
        exp = annexb_expected_q.pop_front();
        if (got !== exp)
          report_error($sformatf(
            "result %0d: got byte=%h end=%b key=%b nps=%b trunc=%b, want %h %b %b %b %b",
            n_results, got.out_byte, got.out_end, got.is_key, got.need_param_sets,
            got.truncated, exp.out_byte, exp.out_end, exp.is_key, exp.need_param_sets,
            exp.truncated));
        if (exp.out_end) begin
          n_samples++;
          n_key   += exp.is_key;
          n_param += exp.need_param_sets;
          n_trunc += exp.truncated;
        end
      end
    end
  end

  // Watchdog on cycles with no item taken on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item taken for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Directed: one byte that ends the sample inside the first prefix
  task automatic test_single_byte_sample();
    sample_q.push_back(8'hFF);
    send_sample();
  endtask

  // Directed: empty NAL followed by a lone IDR, so parameter sets are needed
  task automatic test_zero_length_nal();
    push_prefix(32'd0);
    sample_q.push_back(8'h00);
    sample_q.push_back(8'h00);
    sample_q.push_back(8'h00);
    sample_q.push_back(8'h01);
    sample_q.push_back(8'h05);
    send_sample();
  endtask

  // Directed: SPS then IDR with header high bits set
  task automatic test_sps_then_idr();
    push_nal({3'b011, NAL_SPS}, 0);
    push_nal({3'b111, NAL_IDR}, 0);
    send_sample();
  endtask

  // Directed: non-key slice whose body is cut short
  task automatic test_truncated_body();
    push_prefix(32'd3);
    sample_q.push_back(8'h41);
    sample_q.push_back(8'hFF);
    send_sample();
  endtask

  // Receiver holds off while the sender keeps offering a long sample
  task automatic test_output_hold();
    sender_steady = 1'b1;
    hold_req      = 1'b1;
    push_nal({3'b000, NAL_SEI}, 20);
    push_nal({3'b010, NAL_IDR}, 12);
    send_sample();
    sender_steady = 1'b0;
  endtask

  // Random: mostly well-formed samples, some cut short, some raw noise
  task automatic test_random_samples();
    int unsigned start;
    int unsigned kind;
    int unsigned keep;
    start = sent_items;
    while (sent_items - start < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        build_sample();
      end else if (kind < 17) begin
        build_sample();
        if (sample_q.size() > 1) begin
          keep = $urandom_range(1, sample_q.size() - 1);
          sample_q = sample_q[0:keep-1];
        end
      end else begin
        repeat ($urandom_range(1, 8)) sample_q.push_back(8'($urandom));
      end
      send_sample();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.in_byte    = 8'h00;
    in_if.sample_end = 1'b0;
    clear_parser();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_sample();
    test_zero_length_nal();
    test_sps_then_idr();
    test_truncated_body();
    test_output_hold();
    test_random_samples();

    in_if.valid <= 1'b0;
    while (annexb_expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d bytes in %0d samples: %0d key, %0d need param sets, %0d truncated",
             sent_items, n_samples, n_key, n_param, n_trunc);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
